// File: rtl/open_addressing_hash_insert_defines.svh
// Assertion macros shared by the hash table modules.
`ifndef OPEN_ADDRESSING_HASH_INSERT_DEFINES_SVH
`define OPEN_ADDRESSING_HASH_INSERT_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define OAH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define OAH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define OAH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/oahi_pkg.sv
// Types and constants shared by the hash table modules.
`timescale 1ns / 1ps

package oahi_pkg;

  localparam int KEY_W = 34;
  localparam int NAME_W = 64;
  localparam int SLOT_W = 4;
  localparam int PROBE_W = 5;
  localparam int OP_W = 2;
  localparam int STAT_W = 2;
  localparam int DIG_W = 2;
  localparam int HASH_STEPS = 3;

  localparam logic [OP_W-1:0] OP_INS_LINEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_INS_QUAD = 2'd1;
  localparam logic [OP_W-1:0] OP_READ = 2'd2;
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  localparam logic [STAT_W-1:0] STAT_INSERTED = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] STAT_VALID = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0] opcode;
    logic [KEY_W-1:0] record_key;
    logic [NAME_W-1:0] record_name;
    logic [SLOT_W-1:0] read_index;
  } in_beat_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot_index;
    logic [PROBE_W-1:0] probe_count;
    logic [KEY_W-1:0] out_key;
    logic [NAME_W-1:0] out_name;
  } out_beat_t;

  typedef struct packed {
    logic clr_wr;
    logic load;
    logic hash_step;
    logic probe_init;
    logic probe_step;
    logic ins_write;
    logic res_probe;
    logic res_read;
    logic rd_from_rem;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_insert;
    logic hash_last;
    logic slot_free;
    logic probe_last;
  } sts_t;

endpackage

// File: rtl/oahi_dp.sv
// Datapath: modulo unit, probe sequence, slot memory and result registers.
`timescale 1ns / 1ps
`include "open_addressing_hash_insert_defines.svh"

module oahi_dp #(
  parameter int TABLE_SIZE = 16,
  parameter int NAME_BITS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  oahi_pkg::in_beat_t   in_data_i,
  output oahi_pkg::out_beat_t  out_data_o,
  input  oahi_pkg::cmd_t       cmd_i,
  output oahi_pkg::sts_t       sts_o
);

  localparam int AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int KW = oahi_pkg::KEY_W;
  localparam int NMW = oahi_pkg::NAME_W;
  localparam int SW = oahi_pkg::SLOT_W;
  localparam int PW = oahi_pkg::PROBE_W;
  localparam int DW = oahi_pkg::DIG_W;
  localparam int EW = 1 + KW + NAME_BITS;
  localparam int PMAX = (1 << PW) - 1;
  localparam int HW = KW / 2;
  localparam int FW = HW + AW;
  localparam int MW = FW + 1;
  localparam int SHR = FW + AW;
  localparam logic [AW-1:0] FOLD_R = AW'((64'd1 << HW) % 64'(TABLE_SIZE));
  localparam logic [MW-1:0] RECIP =
    MW'(((64'd1 << SHR) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE));
  localparam logic [FW-1:0] NF = FW'(TABLE_SIZE);
  localparam logic [AW:0] NW = (AW+1)'(TABLE_SIZE);
  localparam logic [AW-1:0] LAST = AW'(TABLE_SIZE - 1);
  localparam logic [PW-1:0] FULL_PROBES =
    (TABLE_SIZE - 1 > PMAX) ? PW'(PMAX) : PW'(TABLE_SIZE - 1);

  logic [oahi_pkg::OP_W-1:0] op_q;
  logic [KW-1:0] key_q;
  logic [NAME_BITS-1:0] name_q;
  logic [KW-1:0] val_q;
  logic [FW-1:0] fold_q, q_q;
  logic [DW-1:0] dig_q;
  logic [AW-1:0] rem_q, home_q, s_q, d_q, i_q, clr_q;
  logic [EW-1:0] mem [TABLE_SIZE];
  logic [EW-1:0] rd_q;
  oahi_pkg::out_beat_t res_q, out_q;

  logic in_insert;
  logic [FW-1:0] fold_next;
  logic [FW+MW-1:0] prod;
  logic [FW-1:0] q_next, qn;
  logic [AW-1:0] rem_next;
  logic [AW:0] sum_s, sum_d;
  logic [AW-1:0] s_next, d_wrap, d_next;
  logic [AW-1:0] raddr, waddr;
  logic wr_en;
  logic [EW-1:0] wdata;
  logic slot_free;
  logic [KW-1:0] rd_key;
  logic [NAME_BITS-1:0] rd_name;
  logic [PW-1:0] probe_sat;

  assign in_insert = !((in_data_i.opcode == oahi_pkg::OP_READ) ||
                       (in_data_i.opcode == oahi_pkg::OP_SPARE));

  // The key is reduced in three steps: the upper half is folded onto the lower half,
  // a reciprocal multiplication gives the quotient, and a subtraction leaves the remainder.
  assign fold_next = FW'(val_q[KW-1:HW]) * FW'(FOLD_R) + FW'(val_q[HW-1:0]);
  assign prod = (FW+MW)'(fold_q) * (FW+MW)'(RECIP);
  assign q_next = FW'(prod >> SHR);
  assign qn = q_q * NF;
  assign rem_next = AW'(fold_q - qn);

  // The quadratic step i*i is kept as a running sum of odd numbers.
  assign sum_s = {1'b0, s_q} + {1'b0, d_q};
  assign s_next = (sum_s >= NW) ? AW'(sum_s - NW) : AW'(sum_s);
  assign sum_d = {1'b0, d_q} + (AW+1)'(2);
  assign d_wrap = (sum_d >= NW) ? AW'(sum_d - NW) : AW'(sum_d);
  assign d_next = (op_q == oahi_pkg::OP_INS_LINEAR) ? d_q : d_wrap;

  assign raddr = cmd_i.rd_from_rem ? rem_q : s_next;
  assign wr_en = cmd_i.clr_wr || cmd_i.ins_write;
  assign waddr = cmd_i.clr_wr ? clr_q : s_q;
  assign wdata = cmd_i.clr_wr ? '0 : {1'b1, key_q, name_q};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  assign slot_free = !rd_q[EW-1];
  assign rd_key = rd_q[EW-2 -: KW];
  assign rd_name = rd_q[NAME_BITS-1:0];
  assign probe_sat = (32'(i_q) > PMAX) ? PW'(PMAX) : PW'(i_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= oahi_pkg::OP_INS_LINEAR;
      dig_q <= '0;
      rem_q <= '0;
      home_q <= '0;
      s_q <= '0;
      d_q <= '0;
      i_q <= '0;
      clr_q <= '0;
    end else begin
      if (cmd_i.clr_wr) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cmd_i.load) begin
        op_q <= in_data_i.opcode;
        dig_q <= DW'(oahi_pkg::HASH_STEPS);
        rem_q <= '0;
      end else if (cmd_i.hash_step) begin
        dig_q <= dig_q - DW'(1);
        if (dig_q == DW'(1)) begin
          rem_q <= rem_next;
        end
      end
      if (cmd_i.probe_init) begin
        home_q <= rem_q;
        s_q <= rem_q;
        d_q <= AW'(1);
        i_q <= '0;
      end else if (cmd_i.probe_step) begin
        s_q <= s_next;
        d_q <= d_next;
        i_q <= i_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q <= in_data_i.record_key;
      name_q <= in_data_i.record_name[NAME_BITS-1:0];
      val_q <= in_insert ? in_data_i.record_key : KW'(in_data_i.read_index);
    end
    if (cmd_i.hash_step) begin
      fold_q <= fold_next;
      q_q <= q_next;
    end
    if (cmd_i.res_probe) begin
      res_q.out_key <= '0;
      res_q.out_name <= '0;
      if (slot_free) begin
        res_q.status <= oahi_pkg::STAT_INSERTED;
        res_q.slot_index <= SW'(s_q);
        res_q.probe_count <= probe_sat;
      end else begin
        res_q.status <= oahi_pkg::STAT_FULL;
        res_q.slot_index <= SW'(home_q);
        res_q.probe_count <= FULL_PROBES;
      end
    end else if (cmd_i.res_read) begin
      res_q.slot_index <= SW'(rem_q);
      res_q.probe_count <= '0;
      if (slot_free) begin
        res_q.status <= oahi_pkg::STAT_EMPTY;
        res_q.out_key <= '0;
        res_q.out_name <= '0;
      end else begin
        res_q.status <= oahi_pkg::STAT_VALID;
        res_q.out_key <= rd_key;
        res_q.out_name <= NMW'(rd_name);
      end
    end
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  assign out_data_o = out_q;

  assign sts_o.clr_last = (clr_q == LAST);
  assign sts_o.is_insert = !((op_q == oahi_pkg::OP_READ) || (op_q == oahi_pkg::OP_SPARE));
  assign sts_o.hash_last = (dig_q == DW'(1));
  assign sts_o.slot_free = slot_free;
  assign sts_o.probe_last = (i_q == LAST);

  `OAH_ASSERT(a_dp_range, ({1'b0, rem_q} < NW) && ({1'b0, s_q} < NW) && ({1'b0, d_q} < NW), "probe address left the table")
  `OAH_ASSERT_NXT(a_dp_ins_res, cmd_i.ins_write, res_q.status == oahi_pkg::STAT_INSERTED, "write without insert result")

endmodule

// File: rtl/oahi_ctrl.sv
// Controller: sequences clearing, hashing, probing, reads and result hand-off.
`timescale 1ns / 1ps
`include "open_addressing_hash_insert_defines.svh"

module oahi_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  oahi_pkg::sts_t  sts_i,
  output oahi_pkg::cmd_t  cmd_o
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_HASH = 3'd2;
  localparam logic [2:0] ST_PSTART = 3'd3;
  localparam logic [2:0] ST_PROBE = 3'd4;
  localparam logic [2:0] ST_RISSUE = 3'd5;
  localparam logic [2:0] ST_RCHECK = 3'd6;
  localparam logic [2:0] ST_DONE = 3'd7;

  logic [2:0] state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_comb begin
    cmd_o = '0;
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = ST_HASH;
        end
      end
      ST_HASH: begin
        cmd_o.hash_step = 1'b1;
        if (sts_i.hash_last) begin
          state_d = sts_i.is_insert ? ST_PSTART : ST_RISSUE;
        end
      end
      ST_PSTART: begin
        cmd_o.probe_init = 1'b1;
        cmd_o.rd_from_rem = 1'b1;
        state_d = ST_PROBE;
      end
      ST_PROBE: begin
        if (sts_i.slot_free) begin
          cmd_o.ins_write = 1'b1;
          cmd_o.res_probe = 1'b1;
          state_d = ST_DONE;
        end else if (sts_i.probe_last) begin
          cmd_o.res_probe = 1'b1;
          state_d = ST_DONE;
        end else begin
          cmd_o.probe_step = 1'b1;
        end
      end
      ST_RISSUE: begin
        cmd_o.rd_from_rem = 1'b1;
        state_d = ST_RCHECK;
      end
      ST_RCHECK: begin
        cmd_o.res_read = 1'b1;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = cmd_o.out_load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  `OAH_ASSERT_IMP(a_ctl_room, cmd_o.out_load, !out_valid_q || out_ready_i, "result overwrote a waiting beat")
  `OAH_ASSERT_NXT(a_ctl_busy, in_valid_i && in_ready_o, !in_ready_o, "second beat taken while busy")
  `OAH_ASSERT_IMP(a_ctl_rise, $rose(out_valid_q), $past(cmd_o.out_load), "output valid without a result")

endmodule

// File: rtl/open_addressing_hash_insert.sv
// Top level of the open-addressing hash table with linear and quadratic probing.
`timescale 1ns / 1ps

// After reset the block clears the valid bit of every slot, one slot per cycle, so it
// accepts no beat until every slot is clear. An insert folds the key, multiplies by a
// reciprocal and subtracts in the key modulo unit, then reads the home slot; the slot
// memory serves one probe per cycle, and an insert makes at most TABLE_SIZE - 1 probes
// beyond the home slot. Results leave through an output register, so the next beat is
// taken while a finished result still waits on the output; a second finished result
// waits until the output register is free.
module open_addressing_hash_insert #(
  parameter int TABLE_SIZE = 16,
  parameter int NAME_BITS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  oahi_pkg::in_beat_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output oahi_pkg::out_beat_t  out_data_o
);

  oahi_pkg::cmd_t cmd;
  oahi_pkg::sts_t sts;

  oahi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  oahi_dp #(
    .TABLE_SIZE(TABLE_SIZE),
    .NAME_BITS (NAME_BITS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_data_i (in_data_i),
    .out_data_o(out_data_o),
    .cmd_i     (cmd),
    .sts_o     (sts)
  );

endmodule
